FILE: hdl/sfl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sharpening arithmetic of the 3x3 sharpen filter.
// No dependencies.
package sfl_pkg;

  localparam int FW_W        = 12;
  localparam int FH_W        = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int OUT_COL_W   = 11;
  localparam int OUT_ROW_W   = 12;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]           out_red;
    logic [7:0]           out_green;
    logic [7:0]           out_blue;
    logic [7:0]           out_alpha;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 run_end;
    logic                 frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } argb_t;

  typedef struct packed {
    logic has_a;
    logic has_b;
    logic has_c;
    logic border;
    logic last_col;
  } cls_t;

  typedef struct packed {
    argb_t a_px;
    argb_t mid;
    argb_t cur;
    cls_t  cls;
  } ent_t;

  function automatic logic [7:0] sharp_chan(logic [7:0] c, logic [7:0] u, logic [7:0] d,
                                            logic [7:0] l, logic [7:0] r);
    logic signed [11:0] v;
    logic [7:0]         res;
    v = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c}) - $signed({4'b0000, u})
      - $signed({4'b0000, d}) - $signed({4'b0000, l}) - $signed({4'b0000, r});
    if (v[11]) begin
      res = 8'h00;
    end else if (v[10:8] != 3'b000) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic argb_t sharpen(argb_t ctr, argb_t up, argb_t dn, argb_t lf, argb_t rt);
    argb_t res;
    res.a = ALPHA_OPAQUE;
    res.r = sharp_chan(ctr.r, up.r, dn.r, lf.r, rt.r);
    res.g = sharp_chan(ctr.g, up.g, dn.g, lf.g, rt.g);
    res.b = sharp_chan(ctr.b, up.b, dn.b, lf.b, rt.b);
    return res;
  endfunction

endpackage

FILE: hdl/sfl_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; a read of the address being written returns the old word.
module sfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/sfl_front.sv
`timescale 1ns / 1ps
// Front end: frame geometry registers, position counters, line stores, 3x3 window and
// classification of each pixel into its pending results. Uses sfl_pkg and sfl_ram.
module sfl_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int COL_W      = 11,
  parameter int ROW_W      = 12,
  parameter int QDEPTH     = 4,
  parameter int QCNT_W     = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sfl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sfl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sfl_pkg::pix_in_t                 in_data_i,
  input  logic [QCNT_W-1:0]                q_count_i,
  output logic                             push_o,
  output sfl_pkg::ent_t                    ent_o,
  output logic [COL_W-1:0]                 ent_col_o,
  output logic [ROW_W-1:0]                 ent_row_o
);
  import sfl_pkg::*;

  localparam int WRST = (FRAME_WIDTH_RST < MAX_WIDTH) ? FRAME_WIDTH_RST : MAX_WIDTH;
  localparam int HRST = (FRAME_HEIGHT_RST < MAX_HEIGHT) ? FRAME_HEIGHT_RST : MAX_HEIGHT;
  localparam logic [COL_W-1:0] W_LAST_RST = COL_W'(WRST - 1);
  localparam logic [ROW_W-1:0] H_LAST_RST = ROW_W'(HRST - 1);

  logic [COL_W-1:0] w_last_q, w_last_d, col_q;
  logic [ROW_W-1:0] h_last_q, h_last_d, row_q;
  logic [FW_W-1:0]  cfg_w;
  logic [FH_W-1:0]  cfg_h;
  logic             acc;
  cls_t             cls_d;

  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  argb_t            s1_cur_q;
  cls_t             s1_cls_q;

  logic             byp_valid_q;
  logic [COL_W-1:0] byp_addr_q;
  argb_t            byp_up_q, byp_lo_q;

  argb_t            win_up_q, win_ctr_q, win_lf_q, win_dn_q;
  argb_t            up_rd, lo_rd, up_eff, mid_eff, sharp;
  logic             byp_hit;

  assign cfg_w = cfg_wdata_i[FW_W-1:0];
  assign cfg_h = cfg_wdata_i[FH_W-1:0];

  always_comb begin
    if (cfg_w == '0) begin
      w_last_d = '0;
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      w_last_d = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last_d = COL_W'(32'(cfg_w) - 32'd1);
    end
    if (cfg_h == '0) begin
      h_last_d = '0;
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      h_last_d = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last_d = ROW_W'(32'(cfg_h) - 32'd1);
    end
  end

  assign in_ready_o = (32'(q_count_i) + 32'(s1_valid_q)) < QDEPTH;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cls_d.has_a    = (row_q != '0) && (col_q != '0);
    cls_d.has_b    = (row_q != '0) && (col_q == w_last_q);
    cls_d.has_c    = (row_q == h_last_q);
    cls_d.border   = (col_q == COL_W'(1)) || (row_q == ROW_W'(1));
    cls_d.last_col = (col_q == w_last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q    <= W_LAST_RST;
      h_last_q    <= H_LAST_RST;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      win_up_q    <= '0;
      win_ctr_q   <= '0;
      win_lf_q    <= '0;
      win_dn_q    <= '0;
    end else begin
      s1_valid_q  <= acc;
      byp_valid_q <= s1_valid_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  w_last_q <= w_last_d;
          CFG_FRAME_HEIGHT: h_last_q <= h_last_d;
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (acc) begin
        if (col_q == w_last_q) begin
          col_q <= '0;
          row_q <= (row_q == h_last_q) ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (s1_valid_q) begin
        win_lf_q  <= win_ctr_q;
        win_up_q  <= up_eff;
        win_ctr_q <= mid_eff;
        win_dn_q  <= s1_cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      s1_cls_q <= cls_d;
      s1_cur_q <= '{a: in_data_i.in_alpha, r: in_data_i.in_red,
                    g: in_data_i.in_green, b: in_data_i.in_blue};
    end
    byp_addr_q <= s1_col_q;
    byp_up_q   <= mid_eff;
    byp_lo_q   <= s1_cur_q;
  end

  sfl_ram #(.WIDTH($bits(argb_t)), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (mid_eff),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  sfl_ram #(.WIDTH($bits(argb_t)), .DEPTH(MAX_WIDTH)) u_line_lower (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_cur_q),
    .raddr_i (col_q),
    .rdata_o (lo_rd)
  );

  // forward last cycle's store write when it hit the address just read
  assign byp_hit = byp_valid_q && (byp_addr_q == s1_col_q);
  assign up_eff  = byp_hit ? byp_up_q : up_rd;
  assign mid_eff = byp_hit ? byp_lo_q : lo_rd;

  assign sharp = sharpen(win_ctr_q, win_up_q, win_dn_q, win_lf_q, mid_eff);

  assign push_o     = s1_valid_q && (s1_cls_q.has_a || s1_cls_q.has_b || s1_cls_q.has_c);
  assign ent_o.a_px = s1_cls_q.border ? win_ctr_q : sharp;
  assign ent_o.mid  = mid_eff;
  assign ent_o.cur  = s1_cur_q;
  assign ent_o.cls  = s1_cls_q;
  assign ent_col_o  = s1_col_q;
  assign ent_row_o  = s1_row_q;

endmodule

FILE: hdl/sfl_queue.sv
`timescale 1ns / 1ps
// Short register FIFO that decouples the front end from the result sequencer.
// No dependencies.
module sfl_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

FILE: hdl/sfl_back.sv
`timescale 1ns / 1ps
// Back end: expands each queued pixel into its one to three results and drives the
// registered output channel. Uses sfl_pkg.
module sfl_back #(
  parameter int COL_W = 11,
  parameter int ROW_W = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  sfl_pkg::ent_t      ent_i,
  input  logic [COL_W-1:0]   col_i,
  input  logic [ROW_W-1:0]   row_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sfl_pkg::pix_out_t  out_data_o
);
  import sfl_pkg::*;

  logic [2:0]       done_q, rem, sel, rest;
  logic             out_valid_q, can_load, fire, last;
  pix_out_t         out_q, res;
  argb_t            px;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             fe;

  assign rem = {ent_i.cls.has_c, ent_i.cls.has_b, ent_i.cls.has_a} & ~done_q;

  always_comb begin
    if (rem[0]) begin
      sel = 3'b001;
      px  = ent_i.a_px;
      col = col_i - COL_W'(1);
      row = row_i - ROW_W'(1);
      fe  = 1'b0;
    end else if (rem[1]) begin
      sel = 3'b010;
      px  = ent_i.mid;
      col = col_i;
      row = row_i - ROW_W'(1);
      fe  = 1'b0;
    end else begin
      sel = 3'b100;
      px  = ent_i.cur;
      col = col_i;
      row = row_i;
      fe  = ent_i.cls.last_col;
    end
    rest = rem & ~sel;
    last = (rest == 3'b000);
    res.out_red   = px.r;
    res.out_green = px.g;
    res.out_blue  = px.b;
    res.out_alpha = px.a;
    res.out_col   = OUT_COL_W'(32'(col));
    res.out_row   = OUT_ROW_W'(32'(row));
    res.run_end   = last;
    res.frame_end = fe;
  end

  assign can_load = !out_valid_q || out_ready_i;
  assign fire     = valid_i && can_load;
  assign pop_o    = fire && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        done_q      <= last ? '0 : (done_q | sel);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/sharpen_filter_3x3_unit.sv
`timescale 1ns / 1ps
// Top level of the 3x3 sharpen filter: front end, decoupling queue and result sequencer.
// Depends on sfl_pkg, sfl_front, sfl_queue and sfl_back.
//
// Takes one ARGB pixel per clock in raster order and gives one result per clock while
// the output is not stalled. A pixel is accepted every cycle while the output keeps up;
// the output port, one result a cycle, sets the sustained rate: the first row gives no
// results, each later row gives w results for its w pixels (none at the first column,
// two at the last), the last row up to three per pixel. A result passes the line store
// read, the queue and the output register in that order. Line stores are not cleared
// after reset; results never depend on unwritten entries. A geometry write restarts the
// frame at column 0, row 0; the user makes it only while idle; the block does not check.
module sharpen_filter_3x3_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sfl_pkg::pix_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sfl_pkg::pix_out_t               out_data_o
);
  import sfl_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int QW     = $bits(ent_t) + COL_W + ROW_W;

  logic              push, pop, q_valid;
  logic [QCNT_W-1:0] q_count;
  ent_t              f_ent, b_ent;
  logic [COL_W-1:0]  f_col, b_col;
  logic [ROW_W-1:0]  f_row, b_row;
  logic [QW-1:0]     q_wdata, q_rdata;

  sfl_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W),
    .QDEPTH     (QDEPTH),
    .QCNT_W     (QCNT_W)
  ) u_sfl_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .ent_o       (f_ent),
    .ent_col_o   (f_col),
    .ent_row_o   (f_row)
  );

  assign q_wdata = {f_ent, f_col, f_row};

  sfl_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_sfl_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid),
    .count_o (q_count)
  );

  assign {b_ent, b_col, b_row} = q_rdata;

  sfl_back #(.COL_W(COL_W), .ROW_W(ROW_W)) u_sfl_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .ent_i       (b_ent),
    .col_i       (b_col),
    .row_i       (b_row),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/sfl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the 3x3 sharpen filter, bound to the top level.
// Depends on sfl_pkg and sharpen_filter_3x3_unit.
module sfl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sfl_pkg::pix_out_t out_data_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  a_frame_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.run_end)
    else $error("frame end not on last result of its pixel");

  // advance straight to the next result of an unfinished run
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.run_end |=> out_valid_o)
    else $error("gap inside a run of results");

endmodule

bind sharpen_filter_3x3_unit sfl_checker u_sfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
